// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. All checks run on the rising edge of
// clock and are quiet while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define STPP_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define STPP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/stpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpp_pkg
// Types and constants shared by the shape table pixel packer.
// ----------------------------------------------------------------------------
package stpp_pkg;

   localparam int IDX_W          = 17;
   localparam int HEAD_BYTES     = 12;
   localparam int COLOUR_ENTRIES = 256;

   localparam logic [1:0] CSR_DISPLAY_MODE = 2'd0;
   localparam logic [1:0] CSR_FONT_BIT     = 2'd1;
   localparam logic [1:0] CSR_PLANAR_BIT   = 2'd2;

   localparam logic [1:0] MODE_CGA  = 2'd0;
   localparam logic [1:0] MODE_EGA  = 2'd1;
   localparam logic [1:0] MODE_GREY = 2'd2;
   localparam logic [1:0] MODE_VGA  = 2'd3;

   typedef enum logic [2:0] {
      PH_HEAD,
      PH_COLOUR,
      PH_WIDTH,
      PH_HEIGHT,
      PH_STORE,
      PH_PIXELS,
      PH_EMIT
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEADER,
      S_FILL,
      S_AREA,
      S_SIZE,
      S_CHECK,
      S_GATHER,
      S_RESP
   } seq_state_type;

   typedef enum logic [1:0] {
      PK_CRUMB,
      PK_NIBBLE,
      PK_PLANE,
      PK_BYTE
   } pack_type;

   typedef enum logic [2:0] {
      STS_NONE     = 3'd0,
      STS_BYTE     = 3'd1,
      STS_BUSY     = 3'd2,
      STS_BAD_BITS = 3'd3,
      STS_OVERRUN  = 3'd4
   } status_type;

   typedef struct packed {
      logic             start;
      logic [IDX_W-1:0] base;
      logic [3:0]       count;
      pack_type         kind;
      logic [3:0]       mask;
   } gather_req_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [7:0]       data;
   } pix_wr_type;

   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [7:0] data;
   } cmap_wr_type;

endpackage

// ===== rtl/core/stpp_gather.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpp_gather
// Pixel store and colour map, plus a small pipeline that reads a run of
// consecutive pixels, translates them and packs them into one output byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stpp_gather #(
   parameter int MAX_PIXELS = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  stpp_pkg::pix_wr_type   pix_wr,
   input  stpp_pkg::cmap_wr_type  cmap_wr,
   input  stpp_pkg::gather_req_type req,
   input  logic [15:0]            area,
   output logic                   done,
   output logic [7:0]             pack_byte
);

   localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam logic [stpp_pkg::IDX_W-1:0] PIX_LIMIT = stpp_pkg::IDX_W'(MAX_PIXELS);

   logic [7:0] pix_mem  [MAX_PIXELS];
   logic [7:0] cmap_mem [stpp_pkg::COLOUR_ENTRIES];

   logic                         busy_ff;
   logic [3:0]                   issued_ff;
   logic [3:0]                   count_ff;
   logic [stpp_pkg::IDX_W-1:0]   base_ff;
   stpp_pkg::pack_type           kind_ff;
   logic [3:0]                   mask_ff;
   logic                         s1_valid_ff;
   logic                         s1_zero_ff;
   logic [2:0]                   s1_slot_ff;
   logic                         s2_valid_ff;
   logic [2:0]                   s2_slot_ff;
   logic [7:0]                   pix_rd_ff;
   logic [7:0]                   col_rd_ff;
   logic [7:0]                   acc_ff;

   logic                         issue;
   logic [stpp_pkg::IDX_W-1:0]   idx;
   logic                         in_range;
   logic [15:0]                  crumb_shift;
   logic [7:0]                   contrib;

   assign issue    = busy_ff && (issued_ff != count_ff);
   assign idx      = base_ff + stpp_pkg::IDX_W'(issued_ff);
   assign in_range = (idx < {1'b0, area}) && (idx < PIX_LIMIT);
   assign done     = busy_ff && !issue && !s1_valid_ff && !s2_valid_ff;
   assign pack_byte = acc_ff;

   // first pixel lands in the top bits
   assign crumb_shift = {8'd0, col_rd_ff} << (3'd6 - {s2_slot_ff[1:0], 1'b0});

   always_comb begin
      unique case (kind_ff)
         stpp_pkg::PK_CRUMB:  contrib = crumb_shift[7:0];
         stpp_pkg::PK_NIBBLE: contrib = s2_slot_ff[0] ? {col_rd_ff[3:0], 4'd0} : col_rd_ff;
         stpp_pkg::PK_PLANE:  contrib = (|(col_rd_ff[3:0] & mask_ff)) ?
                                        (8'h80 >> s2_slot_ff) : 8'd0;
         default:             contrib = col_rd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pix_wr.en) begin
         pix_mem[pix_wr.addr[AW-1:0]] <= pix_wr.data;
      end
      if (issue) begin
         pix_rd_ff <= pix_mem[idx[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmap_wr.en) begin
         cmap_mem[cmap_wr.addr] <= cmap_wr.data;
      end
      if (s1_valid_ff) begin
         col_rd_ff <= cmap_mem[s1_zero_ff ? 8'd0 : pix_rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         issued_ff   <= '0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         if (req.start) begin
            busy_ff   <= 1'b1;
            issued_ff <= '0;
         end else begin
            if (done) begin
               busy_ff <= 1'b0;
            end
            if (issue) begin
               issued_ff <= issued_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_slot_ff <= issued_ff[2:0];
      s1_zero_ff <= !in_range;
      s2_slot_ff <= s1_slot_ff;
      if (req.start) begin
         base_ff  <= req.base;
         count_ff <= req.count;
         kind_ff  <= req.kind;
         mask_ff  <= req.mask;
         acc_ff   <= '0;
      end else if (s2_valid_ff) begin
         acc_ff <= acc_ff | contrib;
      end
   end

   `STPP_ASSERT(a_issue_bound, busy_ff, issued_ff <= count_ff, "gather issued past its count")
   `STPP_ASSERT(a_no_restart, req.start, !busy_ff, "gather started while busy")

endmodule

// ===== rtl/core/sprite_table_pixel_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_table_pixel_packer
// Parses an encoded shape table byte by byte and returns the converted table.
// ----------------------------------------------------------------------------
// One request at a time. A feed goes from idle to the response stage; the
// twelfth header byte adds a header state, and a font or 8-bit identity
// colour table adds a fill of up to 256 entries (one colour map entry per
// cycle). The height byte adds a state for width*height and a completed shape
// adds size and overrun check states; width*height and size share one 8x8
// multiplier. A descriptor byte pull goes straight to the response stage; a
// pixel byte pull first gathers the n pixels (1 to 8) packed into it, one at
// a time through the pixel store's single read port feeding the colour map.
`include "assert_macros.svh"

module sprite_table_pixel_packer #(
   parameter int MAX_PIXELS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_out_address,
   output logic [7:0]  rsp_out_data,
   output logic [15:0] rsp_table_length,
   output logic [15:0] rsp_table_flags,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_data
);

   localparam logic [stpp_pkg::IDX_W-1:0] PIX_LIMIT = stpp_pkg::IDX_W'(MAX_PIXELS);

   stpp_pkg::seq_state_type state_ff, state_in;
   stpp_pkg::phase_type     phase_ff;

   logic [1:0]  cfg_mode_ff;
   logic [3:0]  cfg_font_bit_ff;
   logic [3:0]  cfg_planar_bit_ff;

   logic [15:0] pc_ff;
   logic [7:0]  head_ff [stpp_pkg::HEAD_BYTES];
   logic [15:0] hdr_len_ff;
   logic [15:0] hdr_flags_ff;
   logic [7:0]  hdr_shapes_ff;
   logic [7:0]  hdr_cbits_ff;
   logic [1:0]  hdr_mode_ff;
   logic        hdr_planar_ff;
   logic [7:0]  entry_ff;
   logic [8:0]  fill_ff;
   logic [8:0]  fill_lim_ff;
   logic [7:0]  shape_w_ff;
   logic [7:0]  shape_h_ff;
   logic [15:0] area_ff;
   logic [15:0] size_ff;
   logic [7:0]  shape_cnt_ff;
   logic [15:0] desc_off_ff;
   logic [15:0] data_off_ff;
   logic [16:0] emit_idx_ff;
   logic [7:0]  col_ff;
   logic [7:0]  row_ff;
   logic [1:0]  plane_ff;
   logic [15:0] rowbase_ff;

   stpp_pkg::status_type res_status_ff;
   logic [15:0] res_addr_ff;
   logic [7:0]  res_data_ff;
   logic        res_last_ff;

   logic        rsp_valid_ff;
   stpp_pkg::status_type rsp_status_ff;
   logic [15:0] rsp_addr_ff;
   logic [7:0]  rsp_data_ff;
   logic [15:0] rsp_len_ff;
   logic [15:0] rsp_flags_ff;
   logic        rsp_last_ff;

   logic        accept;
   logic        is_feed;
   logic        rsp_load;
   logic [15:0] pc_next;
   logic [8:0]  w9;
   logic [7:0]  cga_wb;
   logic [7:0]  bpr;
   logic        planar_layout;
   logic [15:0] mul_prod;
   logic [15:0] size_calc;
   logic [16:0] emit_next;
   logic        shape_end;
   logic        shapes_done;
   logic        overrun;
   logic [1:0]  colour_pos;
   logic [7:0]  colour_val;
   logic [10:0] colour_limit;
   logic [15:0] hdr_len_raw;
   logic [15:0] hdr_flags_raw;
   logic        font_hit;
   logic        planar_hit;
   logic [16:0] k_idx;
   logic [9:0]  col4;
   logic [10:0] col8;
   logic [9:0]  rem4;
   logic [10:0] rem8;
   logic        gather_done;
   logic [7:0]  gather_byte;

   stpp_pkg::gather_req_type greq;
   stpp_pkg::pix_wr_type     pix_wr;
   stpp_pkg::cmap_wr_type    cmap_wr;

   // ---------------------------------------------------------------- helpers
   assign accept      = req_valid && !req_stall;
   assign is_feed     = !req_operation;
   assign pc_next     = pc_ff + 16'd1;
   assign w9          = {1'b0, shape_w_ff};
   assign cga_wb      = 8'((w9 + 9'd3) >> 2);
   assign planar_layout = hdr_planar_ff && (hdr_mode_ff != stpp_pkg::MODE_CGA);

   always_comb begin
      priority if (hdr_mode_ff == stpp_pkg::MODE_CGA) begin
         bpr = cga_wb;
      end else if (hdr_mode_ff != stpp_pkg::MODE_VGA && !hdr_planar_ff) begin
         bpr = 8'((w9 + 9'd1) >> 1);
      end else if (hdr_mode_ff != stpp_pkg::MODE_VGA) begin
         bpr = 8'((w9 + 9'd7) >> 3);
      end else if (hdr_planar_ff) begin
         bpr = cga_wb;
      end else begin
         bpr = shape_w_ff;
      end
   end

   // shared multiplier: width*height, then height*bytes-per-row
   assign mul_prod = 16'(shape_h_ff) * 16'((state_ff == stpp_pkg::S_AREA) ? shape_w_ff : bpr);

   always_comb begin
      priority if (hdr_mode_ff == stpp_pkg::MODE_VGA && !hdr_planar_ff) begin
         size_calc = area_ff;
      end else if (planar_layout) begin
         size_calc = {mul_prod[13:0], 2'b00};
      end else begin
         size_calc = mul_prod;
      end
   end

   assign emit_next   = emit_idx_ff + 17'd1;
   assign shape_end   = emit_next >= (17'(size_ff) + 17'd4);
   assign shapes_done = ({1'b0, shape_cnt_ff} + 9'd1) >= {1'b0, hdr_shapes_ff};
   assign overrun     = ({1'b0, area_ff} > PIX_LIMIT) ||
                        (({1'b0, data_off_ff} + {1'b0, size_ff}) >= {1'b0, hdr_len_ff});

   // colour word: only the byte holding the selected field is kept
   assign colour_pos   = pc_ff[1:0];
   assign colour_limit = 11'd4 << hdr_cbits_ff[2:0];
   always_comb begin
      unique case (hdr_mode_ff)
         stpp_pkg::MODE_CGA: colour_val = {6'd0, req_in_byte[1:0]};
         stpp_pkg::MODE_EGA: colour_val = {4'd0, req_in_byte[3:0]};
         default:            colour_val = req_in_byte;
      endcase
   end

   always_comb begin
      unique case (cfg_mode_ff)
         stpp_pkg::MODE_CGA: hdr_len_raw = {head_ff[4], head_ff[3]};
         stpp_pkg::MODE_EGA: hdr_len_raw = {head_ff[6], head_ff[5]};
         default:            hdr_len_raw = {head_ff[8], head_ff[7]};
      endcase
   end
   assign hdr_flags_raw = {head_ff[11], head_ff[10]};
   assign font_hit      = hdr_flags_raw[cfg_font_bit_ff];
   assign planar_hit    = hdr_flags_raw[cfg_planar_bit_ff];

   // pixel run for the next packed byte
   assign k_idx = emit_idx_ff - 17'd4;
   assign col4  = {col_ff, 2'b00};
   assign col8  = {col_ff, 3'b000};
   assign rem4  = {2'b00, shape_w_ff} - col4;
   assign rem8  = {3'b000, shape_w_ff} - col8;

   // ---------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stpp_pkg::S_IDLE: begin
            if (accept) begin
               if (is_feed) begin
                  priority if (phase_ff == stpp_pkg::PH_EMIT) begin
                     state_in = stpp_pkg::S_RESP;
                  end else if (phase_ff == stpp_pkg::PH_HEAD &&
                               pc_next >= 16'(stpp_pkg::HEAD_BYTES)) begin
                     state_in = stpp_pkg::S_HEADER;
                  end else if (phase_ff == stpp_pkg::PH_HEIGHT) begin
                     state_in = stpp_pkg::S_AREA;
                  end else if (phase_ff == stpp_pkg::PH_STORE && area_ff == 16'd0) begin
                     state_in = stpp_pkg::S_SIZE;
                  end else if (phase_ff == stpp_pkg::PH_PIXELS && pc_next >= area_ff) begin
                     state_in = stpp_pkg::S_SIZE;
                  end else begin
                     state_in = stpp_pkg::S_RESP;
                  end
               end else if (phase_ff == stpp_pkg::PH_EMIT && emit_idx_ff >= 17'd4) begin
                  state_in = stpp_pkg::S_GATHER;
               end else begin
                  state_in = stpp_pkg::S_RESP;
               end
            end
         end
         stpp_pkg::S_HEADER: begin
            if (head_ff[9] <= 8'd8 && (font_hit || head_ff[9] == 8'd8)) begin
               state_in = stpp_pkg::S_FILL;
            end else begin
               state_in = stpp_pkg::S_RESP;
            end
         end
         stpp_pkg::S_FILL: begin
            if (fill_ff + 9'd1 == fill_lim_ff) begin
               state_in = stpp_pkg::S_RESP;
            end
         end
         stpp_pkg::S_AREA:  state_in = stpp_pkg::S_RESP;
         stpp_pkg::S_SIZE:  state_in = stpp_pkg::S_CHECK;
         stpp_pkg::S_CHECK: state_in = stpp_pkg::S_RESP;
         stpp_pkg::S_GATHER: begin
            if (gather_done) begin
               state_in = stpp_pkg::S_RESP;
            end
         end
         default: begin
            if (rsp_load) begin
               state_in = stpp_pkg::S_IDLE;
            end
         end
      endcase
   end

   // ---------------------------------------------------------- outputs
   always_comb begin
      req_stall = (state_ff != stpp_pkg::S_IDLE);
      csr_ready = 1'b1;
      rsp_load  = (state_ff == stpp_pkg::S_RESP) && (!rsp_valid_ff || !rsp_stall);

      pix_wr.en   = (state_ff == stpp_pkg::S_IDLE) && accept && is_feed &&
                    phase_ff == stpp_pkg::PH_PIXELS && ({1'b0, pc_ff} < PIX_LIMIT);
      pix_wr.addr = {1'b0, pc_ff};
      pix_wr.data = req_in_byte;

      if (state_ff == stpp_pkg::S_FILL) begin
         cmap_wr.en   = 1'b1;
         cmap_wr.addr = fill_ff[7:0];
         cmap_wr.data = fill_ff[7:0];
      end else begin
         cmap_wr.en   = (state_ff == stpp_pkg::S_IDLE) && accept && is_feed &&
                        phase_ff == stpp_pkg::PH_COLOUR && colour_pos == 2'd3;
         cmap_wr.addr = pc_ff[9:2];
         cmap_wr.data = entry_ff;
      end

      greq.start = (state_ff == stpp_pkg::S_IDLE) && accept && !is_feed &&
                   phase_ff == stpp_pkg::PH_EMIT && emit_idx_ff >= 17'd4;
      greq.mask  = 4'd8 >> plane_ff;
      priority if (hdr_mode_ff == stpp_pkg::MODE_CGA) begin
         greq.kind  = stpp_pkg::PK_CRUMB;
         greq.base  = 17'(rowbase_ff) + 17'(col4);
         greq.count = (rem4 >= 10'd4) ? 4'd4 : rem4[3:0];
      end else if (hdr_mode_ff != stpp_pkg::MODE_VGA && !hdr_planar_ff) begin
         greq.kind  = stpp_pkg::PK_NIBBLE;
         greq.base  = 17'(rowbase_ff) + 17'({col_ff, 1'b0});
         greq.count = 4'd2;
      end else if (hdr_mode_ff != stpp_pkg::MODE_VGA) begin
         greq.kind  = stpp_pkg::PK_PLANE;
         greq.base  = 17'(rowbase_ff) + 17'(col8);
         greq.count = (rem8 >= 11'd8) ? 4'd8 : rem8[3:0];
      end else if (hdr_planar_ff) begin
         greq.kind  = stpp_pkg::PK_BYTE;
         greq.base  = 17'(rowbase_ff) + 17'(col4) + 17'(2'd3 - plane_ff);
         greq.count = 4'd1;
      end else begin
         greq.kind  = stpp_pkg::PK_BYTE;
         greq.base  = k_idx;
         greq.count = 4'd1;
      end
   end

   stpp_gather #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_gather (
      .clock     (clock),
      .reset     (reset),
      .pix_wr    (pix_wr),
      .cmap_wr   (cmap_wr),
      .req       (greq),
      .area      (area_ff),
      .done      (gather_done),
      .pack_byte (gather_byte)
   );

   // ---------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_mode_ff       <= stpp_pkg::MODE_VGA;
         cfg_font_bit_ff   <= 4'd0;
         cfg_planar_bit_ff <= 4'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            stpp_pkg::CSR_DISPLAY_MODE: cfg_mode_ff       <= csr_data[1:0];
            stpp_pkg::CSR_FONT_BIT:     cfg_font_bit_ff   <= csr_data;
            stpp_pkg::CSR_PLANAR_BIT:   cfg_planar_bit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stpp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // header bytes land by position
   always_ff @(posedge clock) begin
      if (state_ff == stpp_pkg::S_IDLE && accept && is_feed && phase_ff == stpp_pkg::PH_HEAD) begin
         head_ff[pc_ff[3:0]] <= req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= stpp_pkg::PH_HEAD;
         pc_ff         <= '0;
         hdr_len_ff    <= '0;
         hdr_flags_ff  <= '0;
         hdr_shapes_ff <= '0;
         hdr_cbits_ff  <= '0;
         hdr_mode_ff   <= '0;
         hdr_planar_ff <= 1'b0;
         shape_cnt_ff  <= '0;
         desc_off_ff   <= '0;
         data_off_ff   <= '0;
         emit_idx_ff   <= '0;
         area_ff       <= '0;
         size_ff       <= '0;
      end else begin
         unique case (state_ff)
            stpp_pkg::S_IDLE: begin
               if (accept) begin
                  res_status_ff <= stpp_pkg::STS_NONE;
                  res_addr_ff   <= '0;
                  res_data_ff   <= '0;
                  res_last_ff   <= 1'b0;
                  if (is_feed) begin
                     unique case (phase_ff)
                        stpp_pkg::PH_EMIT: res_status_ff <= stpp_pkg::STS_BUSY;
                        stpp_pkg::PH_HEAD: pc_ff <= pc_next;
                        stpp_pkg::PH_COLOUR: begin
                           if (colour_pos == hdr_mode_ff || (colour_pos == 2'd2 &&
                               hdr_mode_ff == stpp_pkg::MODE_VGA)) begin
                              entry_ff <= colour_val;
                           end
                           if (pc_next >= 16'(colour_limit)) begin
                              pc_ff    <= '0;
                              phase_ff <= (hdr_shapes_ff == 8'd0) ? stpp_pkg::PH_HEAD
                                                                  : stpp_pkg::PH_WIDTH;
                           end else begin
                              pc_ff <= pc_next;
                           end
                        end
                        stpp_pkg::PH_WIDTH: begin
                           shape_w_ff <= req_in_byte;
                           phase_ff   <= stpp_pkg::PH_HEIGHT;
                        end
                        stpp_pkg::PH_HEIGHT: begin
                           shape_h_ff <= req_in_byte;
                           phase_ff   <= stpp_pkg::PH_STORE;
                        end
                        stpp_pkg::PH_STORE: begin
                           pc_ff <= '0;
                           if (area_ff != 16'd0) begin
                              phase_ff <= stpp_pkg::PH_PIXELS;
                           end
                        end
                        default: pc_ff <= pc_next;
                     endcase
                  end else if (phase_ff == stpp_pkg::PH_EMIT) begin
                     res_status_ff <= stpp_pkg::STS_BYTE;
                     if (emit_idx_ff < 17'd4) begin
                        res_addr_ff <= desc_off_ff + emit_idx_ff[15:0];
                        unique case (emit_idx_ff[1:0])
                           2'd0: res_data_ff <= data_off_ff[7:0];
                           2'd1: res_data_ff <= data_off_ff[15:8];
                           2'd2: res_data_ff <= (hdr_mode_ff == stpp_pkg::MODE_CGA) ?
                                                cga_wb : shape_w_ff;
                           default: res_data_ff <= shape_h_ff;
                        endcase
                        emit_idx_ff <= emit_next;
                        if (shape_end) begin
                           desc_off_ff  <= desc_off_ff + 16'd4;
                           data_off_ff  <= data_off_ff + size_ff;
                           shape_cnt_ff <= shape_cnt_ff + 8'd1;
                           if (shapes_done) begin
                              res_last_ff <= 1'b1;
                              phase_ff    <= stpp_pkg::PH_HEAD;
                              pc_ff       <= '0;
                           end else begin
                              phase_ff <= stpp_pkg::PH_WIDTH;
                           end
                        end
                     end else begin
                        res_addr_ff <= data_off_ff + k_idx[15:0];
                     end
                  end
               end
            end
            stpp_pkg::S_HEADER: begin
               hdr_len_ff    <= hdr_len_raw + 16'd16;
               hdr_flags_ff  <= hdr_flags_raw;
               hdr_shapes_ff <= head_ff[0];
               hdr_cbits_ff  <= head_ff[9];
               hdr_mode_ff   <= cfg_mode_ff;
               hdr_planar_ff <= planar_hit;
               pc_ff         <= '0;
               shape_cnt_ff  <= '0;
               desc_off_ff   <= '0;
               data_off_ff   <= {6'd0, head_ff[0], 2'b00};
               fill_ff       <= '0;
               fill_lim_ff   <= font_hit ? (9'd1 << head_ff[9][3:0]) : 9'd256;
               if (head_ff[9] > 8'd8) begin
                  res_status_ff <= stpp_pkg::STS_BAD_BITS;
                  phase_ff      <= stpp_pkg::PH_HEAD;
               end else if (!font_hit && head_ff[9] != 8'd8) begin
                  phase_ff <= stpp_pkg::PH_COLOUR;
               end
            end
            stpp_pkg::S_FILL: begin
               fill_ff <= fill_ff + 9'd1;
               if (fill_ff + 9'd1 == fill_lim_ff) begin
                  phase_ff <= (hdr_shapes_ff == 8'd0) ? stpp_pkg::PH_HEAD
                                                      : stpp_pkg::PH_WIDTH;
               end
            end
            stpp_pkg::S_AREA: area_ff <= mul_prod;
            stpp_pkg::S_SIZE: size_ff <= size_calc;
            stpp_pkg::S_CHECK: begin
               if (overrun) begin
                  res_status_ff <= stpp_pkg::STS_OVERRUN;
                  phase_ff      <= stpp_pkg::PH_HEAD;
                  pc_ff         <= '0;
               end else begin
                  phase_ff    <= stpp_pkg::PH_EMIT;
                  emit_idx_ff <= '0;
                  col_ff      <= '0;
                  row_ff      <= '0;
                  plane_ff    <= '0;
                  rowbase_ff  <= '0;
               end
            end
            stpp_pkg::S_GATHER: begin
               if (gather_done) begin
                  res_data_ff <= gather_byte;
                  emit_idx_ff <= emit_next;
                  if (col_ff + 8'd1 == bpr) begin
                     col_ff <= '0;
                     if (row_ff + 8'd1 == shape_h_ff) begin
                        row_ff     <= '0;
                        rowbase_ff <= '0;
                        plane_ff   <= plane_ff + 2'd1;
                     end else begin
                        row_ff     <= row_ff + 8'd1;
                        rowbase_ff <= rowbase_ff + 16'(shape_w_ff);
                     end
                  end else begin
                     col_ff <= col_ff + 8'd1;
                  end
                  if (shape_end) begin
                     desc_off_ff  <= desc_off_ff + 16'd4;
                     data_off_ff  <= data_off_ff + size_ff;
                     shape_cnt_ff <= shape_cnt_ff + 8'd1;
                     if (shapes_done) begin
                        res_last_ff <= 1'b1;
                        phase_ff    <= stpp_pkg::PH_HEAD;
                        pc_ff       <= '0;
                     end else begin
                        phase_ff <= stpp_pkg::PH_WIDTH;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- response
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_data_ff   <= res_data_ff;
         rsp_last_ff   <= res_last_ff;
         rsp_len_ff    <= hdr_len_ff;
         rsp_flags_ff  <= hdr_flags_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_address  = rsp_addr_ff;
   assign rsp_out_data     = rsp_data_ff;
   assign rsp_table_length = rsp_len_ff;
   assign rsp_table_flags  = rsp_flags_ff;
   assign rsp_last         = rsp_last_ff;

   `STPP_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, state_ff != stpp_pkg::S_IDLE, "request accepted but sequencer stayed idle")
   `STPP_ASSERT(a_last_is_byte, rsp_valid && rsp_last, rsp_status == stpp_pkg::STS_BYTE, "last flagged on a non-byte response")
   `STPP_ASSERT(a_quiet_fields, rsp_valid && rsp_status != stpp_pkg::STS_BYTE, rsp_out_data == 8'd0 && rsp_out_address == 16'd0, "data on a non-byte response")
   `STPP_ASSERT(a_emit_range, phase_ff == stpp_pkg::PH_EMIT, emit_idx_ff < (17'(size_ff) + 17'd4), "emit cursor past end of shape")

endmodule

// ===== test/sprite_table_pixel_packer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_table_pixel_packer_tb
// Feeds encoded shape tables into the packer and pulls the converted tables
// back out, under random request and response stalls. A predictor mirrors the
// parser and packer, and every response is checked field by field in order.
// ----------------------------------------------------------------------------
module sprite_table_pixel_packer_tb;
   import stpp_pkg::*;

   localparam int MAXP = 4096;

   typedef struct packed {
      logic       pull;
      logic [7:0] value;
   } request_t;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] address;
      logic [7:0]  data;
      logic [15:0] length;
      logic [15:0] flags;
      logic        last;
   } packed_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = 1'b0;
   logic [7:0]  req_in_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_out_address;
   logic [7:0]  rsp_out_data;
   logic [15:0] rsp_table_length;
   logic [15:0] rsp_table_flags;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [3:0]  csr_data = 4'd0;

   sprite_table_pixel_packer dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------- predictor state ----------------
   logic [1:0] cfg_mode;
   logic [3:0] cfg_font_bit, cfg_planar_bit;
   logic [7:0] colour_lut [COLOUR_ENTRIES];
   logic [7:0] shape_pixels [MAXP];
   logic [7:0] header_buf [12];
   phase_type  phase;
   int unsigned tbl_len, tbl_flags, tbl_shapes, tbl_bits, tbl_mode, tbl_planar;
   int unsigned shapes_done, shape_bytes, byte_cnt, desc_ofs, data_ofs, cursor;
   int unsigned shape_w, shape_h, colour_acc;

   request_t       pending_requests [$];
   packed_result_t expected_results [$];
   int             errors = 0, checked = 0, tables_sent = 0, sent_count = 0;
   int             byte_results = 0, overruns = 0, refusals = 0;
   int unsigned    cycle_count = 0;
   bit             req_taken = 1'b0;

   function automatic bit idle_now();
      if (cycle_count > 4000 && cycle_count < 9000) return 1'b0;
      return $urandom_range(99) < 12;
   endfunction

   function automatic int unsigned lookup_pixel(int unsigned i);
      logic [7:0] p;
      p = 8'd0;
      if (i < shape_w * shape_h && i < MAXP) p = shape_pixels[i];
      return colour_lut[p];
   endfunction

   function automatic int unsigned shape_size_bytes();
      if (tbl_mode == MODE_CGA) return shape_h * ((shape_w + 3) / 4);
      if (tbl_mode != MODE_VGA)
         return tbl_planar ? 4 * shape_h * ((shape_w + 7) / 8) : shape_h * ((shape_w + 1) / 2);
      return tbl_planar ? 4 * shape_h * ((shape_w + 3) / 4) : shape_w * shape_h;
   endfunction

   function automatic int unsigned pack_byte(int unsigned k);
      int unsigned bpr, y, c, x, plsz, p, rem, v, mask;
      v = 0;
      if (tbl_mode == MODE_VGA && !tbl_planar) return lookup_pixel(k);
      if (tbl_mode == MODE_CGA) bpr = (shape_w + 3) / 4;
      else if (tbl_mode != MODE_VGA && !tbl_planar) bpr = (shape_w + 1) / 2;
      else if (tbl_mode != MODE_VGA) bpr = (shape_w + 7) / 8;
      else bpr = (shape_w + 3) / 4;
      if (bpr == 0 || shape_h == 0) return 0;
      plsz = shape_h * bpr;
      p = k / plsz;
      rem = (tbl_mode == MODE_CGA || !tbl_planar) ? k : k % plsz;
      y = rem / bpr;
      c = rem % bpr;
      if (tbl_mode == MODE_CGA) begin
         for (int i = 0; i < 4; i++) begin
            x = 4 * c + i;
            if (x >= shape_w) break;
            v |= (lookup_pixel(x + y * shape_w) << (6 - 2 * i)) & 8'hFF;
         end
      end else if (tbl_mode != MODE_VGA && !tbl_planar) begin
         x = 2 * c;
         v = lookup_pixel(x + y * shape_w) | (lookup_pixel(x + 1 + y * shape_w) << 4);
      end else if (tbl_mode != MODE_VGA) begin
         mask = 8 >> (p & 3);
         for (int i = 0; i < 8; i++) begin
            x = 8 * c + i;
            if (x >= shape_w) break;
            if (lookup_pixel(x + y * shape_w) & mask) v |= 8'h80 >> i;
         end
      end else begin
         v = lookup_pixel(4 * c + (3 - (p & 3)) + y * shape_w);
      end
      return v & 8'hFF;
   endfunction

   function automatic phase_type after_colour_table();
      return (tbl_shapes == 0) ? PH_HEAD : PH_WIDTH;
   endfunction

   function automatic status_type close_header();
      int unsigned at, flags, bits;
      at = (cfg_mode == MODE_CGA) ? 3 : (cfg_mode == MODE_EGA) ? 5 : 7;
      flags = {header_buf[11], header_buf[10]};
      bits = header_buf[9];
      tbl_len = ({header_buf[at + 1], header_buf[at]} + 16) & 16'hFFFF;
      tbl_flags = flags;
      tbl_shapes = header_buf[0];
      tbl_bits = bits;
      tbl_mode = cfg_mode;
      tbl_planar = (flags >> cfg_planar_bit) & 1;
      byte_cnt = 0;
      shapes_done = 0;
      desc_ofs = 0;
      data_ofs = 4 * tbl_shapes;
      if (bits > 8) begin
         phase = PH_HEAD;
         return STS_BAD_BITS;
      end
      if ((flags >> cfg_font_bit) & 1) begin
         for (int c = 0; c < (1 << bits); c++) colour_lut[c & 255] = c[7:0];
         phase = after_colour_table();
      end else if (bits == 8) begin
         for (int c = 0; c < COLOUR_ENTRIES; c++) colour_lut[c] = c[7:0];
         phase = after_colour_table();
      end else begin
         colour_acc = 0;
         phase = PH_COLOUR;
      end
      return STS_NONE;
   endfunction

   function automatic status_type close_shape();
      shape_bytes = shape_size_bytes();
      if (shape_w * shape_h > MAXP || data_ofs + shape_bytes >= tbl_len) begin
         phase = PH_HEAD;
         byte_cnt = 0;
         return STS_OVERRUN;
      end
      cursor = 0;
      phase = PH_EMIT;
      return STS_NONE;
   endfunction

   function automatic status_type feed_byte(logic [7:0] b);
      int unsigned e;
      case (phase)
         PH_HEAD: begin
            header_buf[byte_cnt % 12] = b;
            byte_cnt++;
            if (byte_cnt >= 12) return close_header();
         end
         PH_COLOUR: begin
            colour_acc |= b << (8 * (byte_cnt & 3));
            if ((byte_cnt & 3) == 3) begin
               e = (tbl_mode == MODE_CGA) ? (colour_acc & 3) :
                   (tbl_mode == MODE_EGA) ? ((colour_acc >> 8) & 15) :
                   ((colour_acc >> 16) & 255);
               colour_lut[(byte_cnt >> 2) & 255] = e[7:0];
               colour_acc = 0;
            end
            byte_cnt++;
            if (byte_cnt >= (4 << (tbl_bits & 15))) begin
               byte_cnt = 0;
               phase = after_colour_table();
            end
         end
         PH_WIDTH: begin
            shape_w = b;
            phase = PH_HEIGHT;
         end
         PH_HEIGHT: begin
            shape_h = b;
            phase = PH_STORE;
         end
         PH_STORE: begin
            byte_cnt = 0;
            if (shape_w * shape_h == 0) return close_shape();
            phase = PH_PIXELS;
         end
         default: begin
            if (byte_cnt < MAXP) shape_pixels[byte_cnt] = b;
            byte_cnt++;
            if (byte_cnt >= shape_w * shape_h) return close_shape();
         end
      endcase
      return STS_NONE;
   endfunction

   function automatic packed_result_t predict_request(request_t r);
      packed_result_t o;
      int unsigned idx;
      o = '0;
      if (!r.pull) begin
         o.status = (phase == PH_EMIT) ? STS_BUSY : feed_byte(r.value);
      end else if (phase == PH_EMIT) begin
         idx = cursor;
         o.status = STS_BYTE;
         if (idx < 4) begin
            o.address = desc_ofs + idx;
            case (idx)
               0: o.data = data_ofs[7:0];
               1: o.data = data_ofs[15:8];
               2: o.data = (tbl_mode == MODE_CGA) ? (shape_w + 3) / 4 : shape_w;
               default: o.data = shape_h;
            endcase
         end else begin
            o.address = data_ofs + idx - 4;
            o.data = pack_byte(idx - 4);
         end
         cursor = idx + 1;
         if (cursor >= 4 + shape_bytes) begin
            desc_ofs += 4;
            data_ofs += shape_bytes;
            shapes_done++;
            if (shapes_done >= tbl_shapes) begin
               o.last = 1'b1;
               phase = PH_HEAD;
               byte_cnt = 0;
            end else begin
               phase = PH_WIDTH;
            end
         end
      end
      o.length = tbl_len[15:0];
      o.flags = tbl_flags[15:0];
      return o;
   endfunction

   // ---------------- stimulus helpers ----------------
   task automatic send(bit pull, logic [7:0] b);
      request_t r;
      r.pull = pull;
      r.value = b;
      pending_requests.push_back(r);
      expected_results.push_back(predict_request(r));
      sent_count++;
   endtask

   task automatic wait_idle();
      wait (pending_requests.size() == 0 && expected_results.size() == 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [3:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DISPLAY_MODE: cfg_mode = value[1:0];
         CSR_FONT_BIT:     cfg_font_bit = value;
         CSR_PLANAR_BIT:   cfg_planar_bit = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(logic [3:0] mode, logic [3:0] font_bit, logic [3:0] planar_bit);
      wait_idle();
      write_reg(CSR_DISPLAY_MODE, mode);
      write_reg(CSR_FONT_BIT, font_bit);
      write_reg(CSR_PLANAR_BIT, planar_bit);
   endtask

   // Drains whatever output the current shape has, with an occasional refused feed.
   task automatic drain_shape();
      while (phase == PH_EMIT) begin
         if ($urandom_range(99) < 4) send(1'b0, $urandom_range(255));
         send(1'b1, 8'd0);
      end
   endtask

   // One table: header, optional colour table, shapes, each drained as it completes.
   task automatic send_table(int shapes, int bits, bit font, bit planar, int length,
                             int maxdim, int first_w, int first_h);
      logic [15:0] flags;
      int          pmax, w, h;
      flags = $urandom_range(16'hFFFF);
      flags[cfg_font_bit] = font;
      if (cfg_planar_bit != cfg_font_bit) flags[cfg_planar_bit] = planar;
      tables_sent++;
      send(1'b0, shapes[7:0]);
      send(1'b0, $urandom_range(255));
      send(1'b0, $urandom_range(255));
      for (int i = 0; i < 3; i++) begin
         send(1'b0, length[7:0]);
         send(1'b0, length[15:8]);
      end
      send(1'b0, bits[7:0]);
      send(1'b0, flags[7:0]);
      send(1'b0, flags[15:8]);
      if (phase == PH_COLOUR)
         while (phase == PH_COLOUR) send(1'b0, $urandom_range(255));
      pmax = (bits >= 8) ? 255 : (1 << bits) - 1;
      for (int s = 0; s < shapes && phase == PH_WIDTH; s++) begin
         w = (s == 0 && first_w >= 0) ? first_w : $urandom_range(maxdim);
         h = (s == 0 && first_h >= 0) ? first_h : $urandom_range(maxdim);
         send(1'b0, w[7:0]);
         send(1'b0, h[7:0]);
         send(1'b0, $urandom_range(255));
         while (phase == PH_PIXELS) send(1'b0, $urandom_range(pmax));
         if (phase == PH_HEAD) overruns++;
         drain_shape();
      end
   endtask

   // ---------------- request driver ----------------
   always @(posedge clock) begin
      cycle_count++;
      if (req_valid && !req_stall) req_taken = 1'b1;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (pending_requests.size() != 0 && !idle_now()) begin
            req_valid <= 1'b1;
            req_operation <= pending_requests[0].pull;
            req_in_byte <= pending_requests[0].value;
            void'(pending_requests.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= reset ? 1'b0 : idle_now();
   end

   // ---------------- response monitor ----------------
   always @(posedge clock) begin
      packed_result_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            e = expected_results.pop_front();
            checked++;
            if (e.status == STS_BYTE) byte_results++;
            if (e.status == STS_BUSY) refusals++;
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_out_address !== e.address) begin
               $error("out_address: expected %0d, got %0d", e.address, rsp_out_address);
               errors++;
            end
            if (rsp_out_data !== e.data) begin
               $error("out_data: expected %0d, got %0d", e.data, rsp_out_data);
               errors++;
            end
            if (rsp_table_length !== e.length) begin
               $error("table_length: expected %0d, got %0d", e.length, rsp_table_length);
               errors++;
            end
            if (rsp_table_flags !== e.flags) begin
               $error("table_flags: expected %0h, got %0h", e.flags, rsp_table_flags);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp_last);
               errors++;
            end
         end
      end
   end

   initial begin
      #30_000_000;
      $display("** sprite_table_pixel_packer: FAILED **");
      $finish;
   end

   initial begin
      int bits, mode;
      cfg_mode = MODE_VGA;
      cfg_font_bit = 4'd0;
      cfg_planar_bit = 4'd1;
      phase = PH_HEAD;
      tbl_len = 0; tbl_flags = 0; tbl_shapes = 0; tbl_bits = 0; tbl_mode = 0; tbl_planar = 0;
      shapes_done = 0; shape_bytes = 0; byte_cnt = 0; desc_ofs = 0; data_ofs = 0;
      cursor = 0; shape_w = 0; shape_h = 0; colour_acc = 0;
      foreach (header_buf[i]) header_buf[i] = 8'd0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset config first, then each layout and the corner cases
      send(1'b1, 8'd0);
      send_table(3, 8, 0, 0, 40000, 6, 0, 5);
      send_table(1, 9, 0, 0, 40000, 4, -1, -1);
      send_table(0, 8, 0, 0, 40000, 4, -1, -1);
      send_table(1, 8, 0, 1, 40000, 4, 255, 1);
      send(1'b1, 8'd0);
      configure(MODE_CGA, 4'd15, 4'd15);
      send_table(2, 2, 0, 0, 40000, 7, -1, -1);
      send_table(1, 2, 1, 1, 40000, 7, -1, -1);
      configure(4'hD, 4'd3, 4'd0);
      send_table(2, 4, 0, 0, 40000, 7, -1, -1);
      send_table(2, 4, 0, 1, 40000, 9, -1, -1);
      configure(MODE_GREY, 4'd0, 4'd15);
      send_table(2, 5, 0, 1, 40000, 9, -1, -1);
      send_table(2, 0, 0, 0, 40000, 5, -1, -1);
      send_table(1, 3, 0, 0, 16'hFFF5, 5, 2, 2);
      configure(MODE_VGA, 4'd9, 4'd2);
      send_table(2, 8, 0, 1, 40000, 9, -1, -1);
      send_table(3, 6, 1, 0, 20, 6, 1, 1);
      send_table(1, 8, 0, 0, 60000, 4, 65, 64);
      wait_idle();
      write_reg(2'd3, 4'hF);

      // random tables, mostly well formed
      while (sent_count < 8200) begin
         if ($urandom_range(3) == 0)
            configure($urandom_range(15), $urandom_range(15), $urandom_range(15));
         if ($urandom_range(9) == 0) send(1'b1, 8'd0);
         bits = $urandom_range(99) < 4 ? $urandom_range(9, 255) : $urandom_range(8);
         send_table($urandom_range(99) < 4 ? 0 : $urandom_range(1, 3), bits,
                    $urandom_range(4) == 0, $urandom_range(1),
                    $urandom_range(9) == 0 ? $urandom_range(4, 120) : $urandom_range(300, 65519),
                    $urandom_range(19) == 0 ? 24 : 8, -1, -1);
      end

      wait (pending_requests.size() == 0 && expected_results.size() == 0);
      repeat (20) @(posedge clock);
      $display("Ran %0d tables, %0d requests; %0d output bytes, %0d refused feeds,",
               tables_sent, checked, byte_results, refusals);
      $display("%0d overruns, all layouts and register extremes exercised.", overruns);
      if (errors == 0)
         $display("** sprite_table_pixel_packer: PASSED **");
      else
         $display("** sprite_table_pixel_packer: FAILED **");
      $finish;
   end

endmodule

// ===== sprite_table_pixel_packer.f =====
+incdir+rtl/core
rtl/core/stpp_pkg.sv
rtl/core/stpp_gather.sv
rtl/core/sprite_table_pixel_packer.sv
test/sprite_table_pixel_packer_tb.sv
